// ----- rtl/gyro_bias_autocalibration_core_assert.svh -----
// assertion macros shared by the gyro bias calibration core
`ifndef GYRO_BIAS_AUTOCALIBRATION_CORE_ASSERT_SVH
`define GYRO_BIAS_AUTOCALIBRATION_CORE_ASSERT_SVH

// property checked on every aclk edge outside reset
`define GBAC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error(msg);

// condition that must never be seen outside reset
`define GBAC_ASSERT_NEVER(label, expr, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) !(expr)) \
        else $error(msg);

`endif

// ----- rtl/gbac_pkg.sv -----
// shared types, constants and helpers of the gyro bias calibration core
`timescale 1ns / 1ps
`default_nettype none

package gbac_pkg;

    // item commands
    localparam logic [1:0] CMD_SAMPLE       = 2'd0;
    localparam logic [1:0] CMD_ZERO_HEADING = 2'd1;
    localparam logic [1:0] CMD_RESTART      = 2'd2;

    // configuration register indexes
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 48;
    localparam logic [CFG_IDX_W-1:0] REG_SENSITIVITY  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ALPHA_MEAN   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ALPHA_VAR    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ALPHA_BIAS   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_VAR_THRESH   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_INITIAL_BIAS = 3'd5;

    // lock counter
    localparam int LOCK_LIMIT    = 1024;
    localparam int LOCK_W        = $clog2(LOCK_LIMIT + 1);
    localparam int CAL_THRESHOLD = 128;
    typedef logic [LOCK_W-1:0] lock_t;

    // arithmetic widths
    localparam int OPND_W = 33;
    localparam int PROD_W = 2 * OPND_W;
    localparam int PROD_SUM_W = PROD_W + 1;
    localparam int TERM_W = 52;
    localparam int SUM_W  = 54;
    localparam int HALF_Q16 = 32768;
    localparam logic [16:0] ONE_Q16 = 17'h10000;

    typedef logic [OPND_W-1:0]        opnd_t;
    typedef logic [PROD_W-1:0]        prod_t;
    typedef logic [PROD_SUM_W-1:0]    rsum_t;
    typedef logic signed [OPND_W-1:0] diff_t;
    typedef logic signed [TERM_W-1:0] term_t;
    typedef logic signed [SUM_W-1:0]  sum_t;

    localparam sum_t HEAD_MAX = sum_t'(48'sh7FFF_FFFF_FFFF);
    localparam sum_t HEAD_MIN = sum_t'(48'sh8000_0000_0000);
    localparam sum_t Q32_MAX  = sum_t'(32'sh7FFF_FFFF);
    localparam sum_t Q32_MIN  = sum_t'(32'sh8000_0000);
    localparam sum_t VAR_MAX  = sum_t'(48'hFFFF_FFFF_FFFF);
    localparam sum_t VAR_MIN  = sum_t'(0);
    localparam logic [47:0] MAX48U = 48'hFFFF_FFFF_FFFF;

    // configuration register file
    typedef struct packed {
        logic [15:0]        sensitivity;
        logic [16:0]        alpha_mean;
        logic [16:0]        alpha_var;
        logic [16:0]        alpha_bias;
        logic [47:0]        var_thresh;
        logic signed [31:0] initial_bias;
    } cfg_t;

    // operand loads of the shared multiplier
    typedef enum logic [2:0] {
        OP_NONE,
        OP_RATE,
        OP_HEAD,
        OP_MEAN,
        OP_SQ,
        OP_VHI,
        OP_VLO,
        OP_BIAS
    } op_sel_t;

    // register updates from the product
    typedef enum logic [3:0] {
        UPD_NONE,
        UPD_RATE,
        UPD_HEAD,
        UPD_MEAN,
        UPD_SQ,
        UPD_VAR,
        UPD_BIAS,
        UPD_CORR,
        UPD_ZERO_HEAD,
        UPD_RESTART,
        UPD_CLR_RATE
    } upd_sel_t;

    // per-cycle datapath command, registered in the controller
    typedef struct packed {
        op_sel_t  op_sel;
        logic     mul_en;
        logic     acc_ld;
        logic     combine;
        upd_sel_t upd;
    } dp_cmd_t;

    localparam dp_cmd_t DP_IDLE = '{
        op_sel:  OP_NONE,
        mul_en:  1'b0,
        acc_ld:  1'b0,
        combine: 1'b0,
        upd:     UPD_NONE
    };

    // handshake strobes toward the datapath
    typedef struct packed {
        logic in_load;
        logic out_ld;
    } dp_io_t;

    // datapath status
    typedef struct packed {
        logic below_thr;
    } dp_stat_t;

    function automatic logic [16:0] clip_weight(input logic [16:0] a);
        return (a > ONE_Q16) ? ONE_Q16 : a;
    endfunction

    function automatic opnd_t mag_of(input diff_t d);
        return d[OPND_W-1] ? opnd_t'(-d) : opnd_t'(d);
    endfunction

    function automatic sum_t clamp(input sum_t v, input sum_t lo, input sum_t hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

endpackage

`default_nettype wire

// ----- rtl/gbac_ctrl.sv -----
// sequencer of the gyro bias calibration core
`timescale 1ns / 1ps
`default_nettype none
`include "gyro_bias_autocalibration_core_assert.svh"

module gbac_ctrl (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [1:0]         s_cmd,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output gbac_pkg::dp_cmd_t       dp_cmd,
    output gbac_pkg::dp_io_t        dp_io,
    input  wire gbac_pkg::dp_stat_t dp_stat
);

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_RATE_OP,
        ST_RATE_MUL,
        ST_RATE_UPD,
        ST_HEAD_OP,
        ST_MEAN_OP,
        ST_HEAD_UPD,
        ST_MEAN_UPD,
        ST_SQ_OP,
        ST_SQ_MUL,
        ST_SQ_UPD,
        ST_VHI_OP,
        ST_VLO_OP,
        ST_VACC,
        ST_VSUM,
        ST_VAR_UPD,
        ST_BIAS_OP,
        ST_BIAS_MUL,
        ST_BIAS_UPD,
        ST_CORR,
        ST_ZERO_HEAD,
        ST_RESTART,
        ST_NOP,
        ST_OUT
    } state_t;

    state_t            state_reg, state_next;
    gbac_pkg::dp_cmd_t cmd_reg, cmd_next;
    logic              s_ready_reg, s_ready_next;
    logic              m_valid_reg, m_valid_next;
    logic              in_load, out_ld;

    assign in_load = s_valid && s_ready_reg;
    assign out_ld  = (state_reg == ST_OUT) && (!m_valid_reg || m_ready);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_load) begin
                    unique case (s_cmd)
                        gbac_pkg::CMD_SAMPLE:       state_next = ST_RATE_OP;
                        gbac_pkg::CMD_ZERO_HEADING: state_next = ST_ZERO_HEAD;
                        gbac_pkg::CMD_RESTART:      state_next = ST_RESTART;
                        default:                    state_next = ST_NOP;
                    endcase
                end
            end
            ST_RATE_OP:   state_next = ST_RATE_MUL;
            ST_RATE_MUL:  state_next = ST_RATE_UPD;
            ST_RATE_UPD:  state_next = ST_HEAD_OP;
            ST_HEAD_OP:   state_next = ST_MEAN_OP;
            ST_MEAN_OP:   state_next = ST_HEAD_UPD;
            ST_HEAD_UPD:  state_next = ST_MEAN_UPD;
            ST_MEAN_UPD:  state_next = ST_SQ_OP;
            ST_SQ_OP:     state_next = ST_SQ_MUL;
            ST_SQ_MUL:    state_next = ST_SQ_UPD;
            ST_SQ_UPD:    state_next = ST_VHI_OP;
            ST_VHI_OP:    state_next = ST_VLO_OP;
            ST_VLO_OP:    state_next = ST_VACC;
            ST_VACC:      state_next = ST_VSUM;
            ST_VSUM:      state_next = ST_VAR_UPD;
            ST_VAR_UPD:   state_next = ST_BIAS_OP;
            ST_BIAS_OP:   state_next = dp_stat.below_thr ? ST_BIAS_MUL : ST_CORR;
            ST_BIAS_MUL:  state_next = ST_BIAS_UPD;
            ST_BIAS_UPD:  state_next = ST_CORR;
            ST_CORR:      state_next = ST_OUT;
            ST_ZERO_HEAD: state_next = ST_OUT;
            ST_RESTART:   state_next = ST_OUT;
            ST_NOP:       state_next = ST_OUT;
            ST_OUT:       state_next = out_ld ? ST_IDLE : ST_OUT;
            default:      state_next = ST_IDLE;
        endcase

        // command that the next state drives into the datapath
        cmd_next = gbac_pkg::DP_IDLE;
        unique case (state_next)
            ST_RATE_OP:   cmd_next.op_sel = gbac_pkg::OP_RATE;
            ST_RATE_MUL:  cmd_next.mul_en = 1'b1;
            ST_RATE_UPD:  cmd_next.upd    = gbac_pkg::UPD_RATE;
            ST_HEAD_OP:   cmd_next.op_sel = gbac_pkg::OP_HEAD;
            ST_MEAN_OP: begin
                cmd_next.mul_en = 1'b1;
                cmd_next.op_sel = gbac_pkg::OP_MEAN;
            end
            ST_HEAD_UPD: begin
                cmd_next.mul_en = 1'b1;
                cmd_next.upd    = gbac_pkg::UPD_HEAD;
            end
            ST_MEAN_UPD:  cmd_next.upd    = gbac_pkg::UPD_MEAN;
            ST_SQ_OP:     cmd_next.op_sel = gbac_pkg::OP_SQ;
            ST_SQ_MUL:    cmd_next.mul_en = 1'b1;
            ST_SQ_UPD:    cmd_next.upd    = gbac_pkg::UPD_SQ;
            ST_VHI_OP:    cmd_next.op_sel = gbac_pkg::OP_VHI;
            ST_VLO_OP: begin
                cmd_next.mul_en = 1'b1;
                cmd_next.op_sel = gbac_pkg::OP_VLO;
            end
            ST_VACC: begin
                cmd_next.mul_en = 1'b1;
                cmd_next.acc_ld = 1'b1;
            end
            ST_VSUM:      cmd_next.combine = 1'b1;
            ST_VAR_UPD:   cmd_next.upd     = gbac_pkg::UPD_VAR;
            ST_BIAS_OP:   cmd_next.op_sel  = gbac_pkg::OP_BIAS;
            ST_BIAS_MUL:  cmd_next.mul_en  = 1'b1;
            ST_BIAS_UPD:  cmd_next.upd     = gbac_pkg::UPD_BIAS;
            ST_CORR:      cmd_next.upd     = gbac_pkg::UPD_CORR;
            ST_ZERO_HEAD: cmd_next.upd     = gbac_pkg::UPD_ZERO_HEAD;
            ST_RESTART:   cmd_next.upd     = gbac_pkg::UPD_RESTART;
            ST_NOP:       cmd_next.upd     = gbac_pkg::UPD_CLR_RATE;
            default:      cmd_next         = gbac_pkg::DP_IDLE;
        endcase

        s_ready_next = (state_next == ST_IDLE);

        if (out_ld) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cmd_reg     <= gbac_pkg::DP_IDLE;
            s_ready_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cmd_reg     <= cmd_next;
            s_ready_reg <= s_ready_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_ready        = s_ready_reg;
    assign m_valid        = m_valid_reg;
    assign dp_cmd         = cmd_reg;
    assign dp_io.in_load  = in_load;
    assign dp_io.out_ld   = out_ld;

    `GBAC_ASSERT(a_busy_after_accept, in_load |=> !s_ready_reg, "ready high right after an accepted word")
    `GBAC_ASSERT(a_valid_from_out, $rose(m_valid_reg) |-> $past(state_reg == ST_OUT), "result raised outside the output state")
    `GBAC_ASSERT_NEVER(a_idle_quiet, (state_reg == ST_IDLE) && (cmd_reg.mul_en || cmd_reg.acc_ld || cmd_reg.combine || (cmd_reg.upd != gbac_pkg::UPD_NONE) || (cmd_reg.op_sel != gbac_pkg::OP_NONE)), "datapath command issued while idle")

endmodule

`default_nettype wire

// ----- rtl/gbac_dpath.sv -----
// datapath of the gyro bias calibration core: shared multiplier and state
`timescale 1ns / 1ps
`default_nettype none
`include "gyro_bias_autocalibration_core_assert.svh"

module gbac_dpath (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire gbac_pkg::cfg_t     cfg,
    input  wire gbac_pkg::dp_cmd_t  cmd,
    input  wire gbac_pkg::dp_io_t   io,
    output gbac_pkg::dp_stat_t      stat,
    input  wire logic signed [15:0] s_raw_sample,
    input  wire logic [15:0]        s_dt_q16,
    output logic signed [31:0]      m_rate_q16,
    output logic signed [32:0]      m_corrected_rate_q16,
    output logic signed [31:0]      m_mean_q16,
    output logic [47:0]             m_variance_q16,
    output logic signed [31:0]      m_bias_q16,
    output logic signed [47:0]      m_heading_q16,
    output logic [10:0]             m_lock_count,
    output logic                    m_calibrated
);

    // latched item
    logic signed [15:0] raw_reg;
    logic [15:0]        dt_reg;

    // multiplier pipeline
    gbac_pkg::opnd_t op_a_reg, op_b_reg;
    logic            neg_reg, neg_p_reg;
    gbac_pkg::prod_t prod_reg, acc_reg;

    // working values
    logic signed [31:0] rate_reg;
    logic signed [32:0] corr_reg;
    logic [47:0]        sq_reg;
    logic [47:0]        vd_reg;

    // estimator state
    logic signed [47:0] heading_reg;
    logic signed [31:0] mean_reg;
    logic [47:0]        var_reg;
    logic signed [31:0] bias_reg;
    gbac_pkg::lock_t    lock_reg;

    // output word
    logic signed [31:0] m_rate_reg;
    logic signed [32:0] m_corr_reg;
    logic signed [31:0] m_mean_reg;
    logic [47:0]        m_var_reg;
    logic signed [31:0] m_bias_reg;
    logic signed [47:0] m_heading_reg;
    logic [10:0]        m_lock_reg;
    logic               m_cal_reg;

    logic signed [16:0] raw_ext;
    logic [16:0]        raw_mag;
    gbac_pkg::diff_t    d_head, d_mean, d_sq, d_bias;
    logic signed [48:0] vdiff;
    logic [48:0]        vmag;
    gbac_pkg::rsum_t    rnd_sum;
    logic [50:0]        scaled;
    gbac_pkg::term_t    term;
    logic signed [32:0] rate_full;
    logic [47:0]        sq_sat;
    gbac_pkg::sum_t     sum_head, sum_mean, sum_var, sum_bias;
    gbac_pkg::sum_t     head_sat, mean_sat, var_sat, bias_sat;

    always_comb begin
        raw_ext = 17'(raw_reg);
        raw_mag = raw_ext[16] ? 17'(-raw_ext) : 17'(raw_ext);

        d_head = gbac_pkg::diff_t'(rate_reg) - gbac_pkg::diff_t'(bias_reg);
        d_mean = gbac_pkg::diff_t'(rate_reg) - gbac_pkg::diff_t'(mean_reg);
        d_sq   = d_mean;
        d_bias = gbac_pkg::diff_t'(mean_reg) - gbac_pkg::diff_t'(bias_reg);

        vdiff = $signed({1'b0, sq_reg}) - $signed({1'b0, var_reg});
        vmag  = vdiff[48] ? 49'(-vdiff) : 49'(vdiff);

        // round half away from zero on the magnitude, then apply the sign
        rnd_sum = {1'b0, prod_reg} + gbac_pkg::rsum_t'(gbac_pkg::HALF_Q16);
        scaled  = rnd_sum[66:16];
        term    = neg_p_reg ? -$signed({1'b0, scaled}) : $signed({1'b0, scaled});

        rate_full = neg_p_reg ? -$signed(prod_reg[32:0]) : $signed(prod_reg[32:0]);
        sq_sat    = (|rnd_sum[66:64]) ? gbac_pkg::MAX48U : rnd_sum[63:16];

        sum_head = gbac_pkg::sum_t'(heading_reg) + gbac_pkg::sum_t'(term);
        sum_mean = gbac_pkg::sum_t'(mean_reg) + gbac_pkg::sum_t'(term);
        sum_var  = gbac_pkg::sum_t'($signed({1'b0, var_reg})) + gbac_pkg::sum_t'(term);
        sum_bias = gbac_pkg::sum_t'(bias_reg) + gbac_pkg::sum_t'(term);

        head_sat = gbac_pkg::clamp(sum_head, gbac_pkg::HEAD_MIN, gbac_pkg::HEAD_MAX);
        mean_sat = gbac_pkg::clamp(sum_mean, gbac_pkg::Q32_MIN, gbac_pkg::Q32_MAX);
        var_sat  = gbac_pkg::clamp(sum_var, gbac_pkg::VAR_MIN, gbac_pkg::VAR_MAX);
        bias_sat = gbac_pkg::clamp(sum_bias, gbac_pkg::Q32_MIN, gbac_pkg::Q32_MAX);
    end

    assign stat.below_thr = (var_reg < cfg.var_thresh);

    // item latch, operand loads and the multiplier
    always_ff @(posedge aclk) begin
        if (io.in_load) begin
            raw_reg <= s_raw_sample;
            dt_reg  <= s_dt_q16;
        end

        unique case (cmd.op_sel)
            gbac_pkg::OP_RATE: begin
                op_a_reg <= gbac_pkg::opnd_t'(raw_mag);
                op_b_reg <= gbac_pkg::opnd_t'(cfg.sensitivity);
                neg_reg  <= raw_reg[15];
            end
            gbac_pkg::OP_HEAD: begin
                op_a_reg <= gbac_pkg::mag_of(d_head);
                op_b_reg <= gbac_pkg::opnd_t'(dt_reg);
                neg_reg  <= d_head[32];
            end
            gbac_pkg::OP_MEAN: begin
                op_a_reg <= gbac_pkg::mag_of(d_mean);
                op_b_reg <= gbac_pkg::opnd_t'(gbac_pkg::clip_weight(cfg.alpha_mean));
                neg_reg  <= d_mean[32];
            end
            gbac_pkg::OP_SQ: begin
                op_a_reg <= gbac_pkg::mag_of(d_sq);
                op_b_reg <= gbac_pkg::mag_of(d_sq);
                neg_reg  <= 1'b0;
            end
            gbac_pkg::OP_VHI: begin
                vd_reg   <= vmag[47:0];
                op_a_reg <= gbac_pkg::opnd_t'(vmag[47:32]);
                op_b_reg <= gbac_pkg::opnd_t'(gbac_pkg::clip_weight(cfg.alpha_var));
                neg_reg  <= vdiff[48];
            end
            gbac_pkg::OP_VLO: begin
                op_a_reg <= gbac_pkg::opnd_t'(vd_reg[31:0]);
            end
            gbac_pkg::OP_BIAS: begin
                op_a_reg <= gbac_pkg::mag_of(d_bias);
                op_b_reg <= gbac_pkg::opnd_t'(gbac_pkg::clip_weight(cfg.alpha_bias));
                neg_reg  <= d_bias[32];
            end
            default: ;
        endcase

        if (cmd.mul_en) begin
            prod_reg  <= op_a_reg * op_b_reg;
            neg_p_reg <= neg_reg;
        end else if (cmd.combine) begin
            // high partial product sits 32 bits up
            prod_reg <= prod_reg + {acc_reg[33:0], 32'd0};
        end

        if (cmd.acc_ld) begin
            acc_reg <= prod_reg;
        end
    end

    // working values
    always_ff @(posedge aclk) begin
        unique case (cmd.upd) inside
            gbac_pkg::UPD_RATE: rate_reg <= rate_full[31:0];
            gbac_pkg::UPD_SQ:   sq_reg   <= sq_sat;
            gbac_pkg::UPD_CORR: corr_reg <= 33'(rate_reg) - 33'(bias_reg);
            gbac_pkg::UPD_ZERO_HEAD, gbac_pkg::UPD_RESTART, gbac_pkg::UPD_CLR_RATE: begin
                rate_reg <= '0;
                corr_reg <= '0;
            end
            default: ;
        endcase
    end

    // estimator state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            heading_reg <= '0;
            mean_reg    <= '0;
            var_reg     <= '0;
            bias_reg    <= '0;
            lock_reg    <= '0;
        end else begin
            unique case (cmd.upd)
                gbac_pkg::UPD_HEAD: begin
                    heading_reg <= head_sat[47:0];
                end
                gbac_pkg::UPD_MEAN: begin
                    mean_reg <= mean_sat[31:0];
                end
                gbac_pkg::UPD_VAR: begin
                    var_reg <= var_sat[47:0];
                end
                gbac_pkg::UPD_BIAS: begin
                    bias_reg <= bias_sat[31:0];
                    if (lock_reg < gbac_pkg::lock_t'(gbac_pkg::LOCK_LIMIT)) begin
                        lock_reg <= lock_reg + 1'b1;
                    end
                end
                gbac_pkg::UPD_ZERO_HEAD: heading_reg <= '0;
                gbac_pkg::UPD_RESTART: begin
                    heading_reg <= '0;
                    mean_reg    <= '0;
                    var_reg     <= '0;
                    lock_reg    <= '0;
                    bias_reg    <= cfg.initial_bias;
                end
                default: ;
            endcase
        end
    end

    // output word, held until taken
    always_ff @(posedge aclk) begin
        if (io.out_ld) begin
            m_rate_reg    <= rate_reg;
            m_corr_reg    <= corr_reg;
            m_mean_reg    <= mean_reg;
            m_var_reg     <= var_reg;
            m_bias_reg    <= bias_reg;
            m_heading_reg <= heading_reg;
            m_lock_reg    <= 11'(lock_reg);
            m_cal_reg     <= (lock_reg >= gbac_pkg::lock_t'(gbac_pkg::CAL_THRESHOLD));
        end
    end

    assign m_rate_q16           = m_rate_reg;
    assign m_corrected_rate_q16 = m_corr_reg;
    assign m_mean_q16           = m_mean_reg;
    assign m_variance_q16       = m_var_reg;
    assign m_bias_q16           = m_bias_reg;
    assign m_heading_q16        = m_heading_reg;
    assign m_lock_count         = m_lock_reg;
    assign m_calibrated         = m_cal_reg;

    `GBAC_ASSERT_NEVER(a_lock_bound, lock_reg > gbac_pkg::lock_t'(gbac_pkg::LOCK_LIMIT), "lock count above its limit")
    `GBAC_ASSERT(a_lock_source, (lock_reg != $past(lock_reg)) |-> ($past(cmd.upd == gbac_pkg::UPD_BIAS) || $past(cmd.upd == gbac_pkg::UPD_RESTART)), "lock count moved without a bias update or restart")

endmodule

`default_nettype wire

// ----- rtl/gyro_bias_autocalibration_core.sv -----
// top level of the gyro bias calibration core: config registers and wiring
// usage:
//  input channel s_valid/s_ready carries one word: s_cmd (sample, zero heading,
//  restart), s_raw_sample and s_dt_q16. result channel m_valid/m_ready returns
//  exactly one word per input word with rate, corrected rate, mean, variance,
//  bias, heading, lock count and calibrated flag.
//  config writes go through cfg_wr_en/cfg_index/cfg_wdata, one cycle each. the user
//  must write only while no word is in flight; the core does not enforce this.
//  a sample word walks a sequencer over one shared 33x33 multiplier: scale,
//  heading and mean products, the square, two partial products for the
//  variance and the bias product, which is skipped when the variance is not
//  below threshold. s_ready rises again in the cycle after the result is
//  loaded; no new word is taken while one is in flight. zero heading, restart
//  and unused commands use no multiplier step before the result is loaded.
//  the result sits in an output register; if the receiver stalls the core
//  finishes the next word and then waits with s_ready low until the register
//  frees up.
//  synchronous reset clears the estimator state and loads the default
//  register values; s_ready rises the cycle after reset is released.
`timescale 1ns / 1ps
`default_nettype none

module gyro_bias_autocalibration_core (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // config write port
    input  wire logic                              cfg_wr_en,
    input  wire logic [gbac_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [gbac_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    // input words
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic [1:0]                        s_cmd,
    input  wire logic signed [15:0]                s_raw_sample,
    input  wire logic [15:0]                       s_dt_q16,
    // result words
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic signed [31:0]                     m_rate_q16,
    output logic signed [32:0]                     m_corrected_rate_q16,
    output logic signed [31:0]                     m_mean_q16,
    output logic [47:0]                            m_variance_q16,
    output logic signed [31:0]                     m_bias_q16,
    output logic signed [47:0]                     m_heading_q16,
    output logic [10:0]                            m_lock_count,
    output logic                                   m_calibrated
);

    gbac_pkg::cfg_t     cfg_reg;
    gbac_pkg::dp_cmd_t  dp_cmd;
    gbac_pkg::dp_io_t   dp_io;
    gbac_pkg::dp_stat_t dp_stat;

    // register file, defaults on reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.sensitivity  <= 16'd1147;
            cfg_reg.alpha_mean   <= 17'd655;
            cfg_reg.alpha_var    <= 17'd3277;
            cfg_reg.alpha_bias   <= 17'd655;
            cfg_reg.var_thresh   <= 48'd65536;
            cfg_reg.initial_bias <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                gbac_pkg::REG_SENSITIVITY:  cfg_reg.sensitivity  <= cfg_wdata[15:0];
                gbac_pkg::REG_ALPHA_MEAN:   cfg_reg.alpha_mean   <= cfg_wdata[16:0];
                gbac_pkg::REG_ALPHA_VAR:    cfg_reg.alpha_var    <= cfg_wdata[16:0];
                gbac_pkg::REG_ALPHA_BIAS:   cfg_reg.alpha_bias   <= cfg_wdata[16:0];
                gbac_pkg::REG_VAR_THRESH:   cfg_reg.var_thresh   <= cfg_wdata[47:0];
                gbac_pkg::REG_INITIAL_BIAS: cfg_reg.initial_bias <= cfg_wdata[31:0];
                // unused indexes are dropped
                default: ;
            endcase
        end
    end

    // sequencer
    gbac_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_cmd   (s_cmd),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .dp_cmd  (dp_cmd),
        .dp_io   (dp_io),
        .dp_stat (dp_stat)
    );

    // arithmetic and estimator state
    gbac_dpath u_dpath (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .cfg                  (cfg_reg),
        .cmd                  (dp_cmd),
        .io                   (dp_io),
        .stat                 (dp_stat),
        .s_raw_sample         (s_raw_sample),
        .s_dt_q16             (s_dt_q16),
        .m_rate_q16           (m_rate_q16),
        .m_corrected_rate_q16 (m_corrected_rate_q16),
        .m_mean_q16           (m_mean_q16),
        .m_variance_q16       (m_variance_q16),
        .m_bias_q16           (m_bias_q16),
        .m_heading_q16        (m_heading_q16),
        .m_lock_count         (m_lock_count),
        .m_calibrated         (m_calibrated)
    );

endmodule

`default_nettype wire

// ----- bench/tb_gyro_bias_autocalibration_core.sv -----
`timescale 1ns / 1ps
// testbench for the gyro bias calibration core: predicted result words checked against the core

module tb_gyro_bias_autocalibration_core;
    import gbac_pkg::*;

    // run control
    localparam int CYCLE_LIMIT   = 500000;
    localparam int SETTLE_CYCLES = 8;     // pause before a register write, core is idle by then
    localparam int DRAIN_CYCLES  = 40;    // quiet time before the final check for stray results
    localparam int REPORT_LIMIT  = 10;

    // command code the core must ignore
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    // lock counter behavior
    localparam int LOCK_STOP = 1024;
    localparam int CAL_LEVEL = 128;

    // all predictor math runs in one wide signed type, wide enough that nothing wraps
    typedef logic signed [95:0] wide_t;
    localparam wide_t HEADING_HI = (wide_t'(1) <<< 47) - 1;
    localparam wide_t HEADING_LO = -(wide_t'(1) <<< 47);
    localparam wide_t Q31_HI     = (wide_t'(1) <<< 31) - 1;
    localparam wide_t Q31_LO     = -(wide_t'(1) <<< 31);
    localparam wide_t VAR_HI     = (wide_t'(1) <<< 48) - 1;
    localparam wide_t ROUND_HALF = 32768;
    localparam logic [47:0] THRESH_ALL = '1;

    // one input word plus a flag that makes the sender drain the core first
    typedef struct {
        logic [1:0]         cmd;
        logic signed [15:0] raw;
        logic [15:0]        dt;
        bit                 hold;
    } sensor_word_t;

    // one predicted result word, fields at the port widths
    typedef struct {
        logic signed [31:0] rate;
        logic signed [32:0] corr;
        logic signed [31:0] mean;
        logic [47:0]        variance;
        logic signed [31:0] bias;
        logic signed [47:0] heading;
        logic [10:0]        lock;
        logic               calibrated;
    } est_word_t;

    // register values as the core should hold them
    typedef struct {
        logic [15:0]        sens;
        logic [16:0]        alpha_mean;
        logic [16:0]        alpha_var;
        logic [16:0]        alpha_bias;
        logic [47:0]        thresh;
        logic signed [31:0] init_bias;
    } tuning_t;

    // dut signals, every input known from time zero
    logic                         aclk         = 1'b0;
    logic                         aresetn      = 1'b0;
    logic                         cfg_wr_en    = 1'b0;
    logic [CFG_IDX_W-1:0]         cfg_index    = '0;
    logic [CFG_DATA_W-1:0]        cfg_wdata    = '0;
    logic                         s_valid      = 1'b0;
    logic                         s_ready;
    logic [1:0]                   s_cmd        = CMD_SAMPLE;
    logic signed [15:0]           s_raw_sample = '0;
    logic [15:0]                  s_dt_q16     = '0;
    logic                         m_valid;
    logic                         m_ready      = 1'b0;
    logic signed [31:0]           m_rate_q16;
    logic signed [32:0]           m_corrected_rate_q16;
    logic signed [31:0]           m_mean_q16;
    logic [47:0]                  m_variance_q16;
    logic signed [31:0]           m_bias_q16;
    logic signed [47:0]           m_heading_q16;
    logic [10:0]                  m_lock_count;
    logic                         m_calibrated;

    // estimator copy kept by the bench
    tuning_t tune = '{sens: 16'd1147, alpha_mean: 17'd655, alpha_var: 17'd3277,
                      alpha_bias: 17'd655, thresh: 48'd65536, init_bias: 32'sd0};
    wide_t est_mean     = 0;
    wide_t est_variance = 0;
    wide_t est_bias     = 0;
    wide_t est_heading  = 0;
    int    est_lock     = 0;
    int    peak_lock    = 0;

    // words waiting to be sent and results waiting to arrive
    sensor_word_t pending_words[$];
    est_word_t    expected_words[$];

    // counters: words_sent and results_seen move by nonblocking assignment only,
    // so any process reading them at a clock edge sees the value from before it
    int words_sent       = 0;
    int results_seen     = 0;
    int items_total      = 0;
    int mismatches       = 0;
    int settings_applied = 0;
    int cycle_count      = 0;

    // pacing knobs, percent of cycles the sender idles and the receiver stalls
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;

    gyro_bias_autocalibration_core u_top (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .cfg_wr_en            (cfg_wr_en),
        .cfg_index            (cfg_index),
        .cfg_wdata            (cfg_wdata),
        .s_valid              (s_valid),
        .s_ready              (s_ready),
        .s_cmd                (s_cmd),
        .s_raw_sample         (s_raw_sample),
        .s_dt_q16             (s_dt_q16),
        .m_valid              (m_valid),
        .m_ready              (m_ready),
        .m_rate_q16           (m_rate_q16),
        .m_corrected_rate_q16 (m_corrected_rate_q16),
        .m_mean_q16           (m_mean_q16),
        .m_variance_q16       (m_variance_q16),
        .m_bias_q16           (m_bias_q16),
        .m_heading_q16        (m_heading_q16),
        .m_lock_count         (m_lock_count),
        .m_calibrated         (m_calibrated)
    );

    // 2 ns clock
    initial begin
        forever #1 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // estimator prediction
    // ------------------------------------------------------------------

    // weights above one behave as exactly one
    function automatic logic [16:0] unit_weight(input logic [16:0] a);
        return (a > 17'd65536) ? 17'd65536 : a;
    endfunction

    // signed difference times a Q16 weight, rounded half away from zero
    function automatic wide_t weighted_step(input wide_t d, input logic [16:0] k);
        wide_t mag;
        wide_t prod;
        mag  = (d < 0) ? -d : d;
        prod = (mag * wide_t'(k) + ROUND_HALF) >>> 16;
        return (d < 0) ? -prod : prod;
    endfunction

    function automatic wide_t saturate(input wide_t v, input wide_t lo, input wide_t hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // apply one word to the bench's estimator and return the result word it yields
    function automatic est_word_t advance_estimator(input logic [1:0] cmd,
                                                    input logic signed [15:0] raw,
                                                    input logic [15:0] dt);
        est_word_t w;
        wide_t     rate;
        wide_t     corr;
        wide_t     dev;
        wide_t     sq;
        rate = 0;
        corr = 0;
        case (cmd)
            CMD_SAMPLE: begin
                rate = wide_t'(raw) * wide_t'(tune.sens);
                // heading integrates against the bias from before this sample
                est_heading = saturate(est_heading + weighted_step(rate - est_bias, {1'b0, dt}),
                                       HEADING_LO, HEADING_HI);
                est_mean = saturate(est_mean +
                                    weighted_step(rate - est_mean, unit_weight(tune.alpha_mean)),
                                    Q31_LO, Q31_HI);
                // squared deviation from the updated mean, Q16
                dev = rate - est_mean;
                if (dev < 0)
                    dev = -dev;
                sq = (dev * dev + ROUND_HALF) >>> 16;
                if (sq > VAR_HI)
                    sq = VAR_HI;
                est_variance = saturate(est_variance +
                                        weighted_step(sq - est_variance,
                                                      unit_weight(tune.alpha_var)),
                                        0, VAR_HI);
                // stable enough: pull the bias toward the mean and count toward lock
                if (est_variance < wide_t'(tune.thresh)) begin
                    est_bias = saturate(est_bias +
                                        weighted_step(est_mean - est_bias,
                                                      unit_weight(tune.alpha_bias)),
                                        Q31_LO, Q31_HI);
                    if (est_lock < LOCK_STOP)
                        est_lock++;
                end
                corr = rate - est_bias;
            end
            CMD_ZERO_HEADING: begin
                est_heading = 0;
            end
            CMD_RESTART: begin
                est_mean     = 0;
                est_variance = 0;
                est_heading  = 0;
                est_lock     = 0;
                est_bias     = wide_t'(tune.init_bias);
            end
            default: begin
                // unused code leaves the estimator alone
            end
        endcase
        if (est_lock > peak_lock)
            peak_lock = est_lock;
        w.rate       = rate[31:0];
        w.corr       = corr[32:0];
        w.mean       = est_mean[31:0];
        w.variance   = est_variance[47:0];
        w.bias       = est_bias[31:0];
        w.heading    = est_heading[47:0];
        w.lock       = est_lock[10:0];
        w.calibrated = (est_lock >= CAL_LEVEL);
        return w;
    endfunction

    // ------------------------------------------------------------------
    // stimulus building
    // ------------------------------------------------------------------

    function automatic void queue_word(input logic [1:0] cmd, input logic signed [15:0] raw,
                                       input logic [15:0] dt, input bit hold);
        sensor_word_t w;
        w.cmd  = cmd;
        w.raw  = raw;
        w.dt   = dt;
        w.hold = hold;
        pending_words.push_back(w);
        items_total++;
    endfunction

    // a restart followed by samples jittering around a fixed offset, which is what
    // lets the variance settle and the bias lock; a minority of words is noise:
    // heading zeroing, fully random words, unused commands, and (optionally) restarts
    function automatic void queue_noisy_run(input int count, input bit allow_restart);
        int         base;
        int         span;
        int         pick;
        logic [1:0] cmd;
        // the leading restart waits for the core to drain completely
        queue_word(CMD_RESTART, 16'($urandom), 16'($urandom), 1'b1);
        base = int'($urandom_range(4000)) - 2000;
        span = $urandom_range(60);
        for (int i = 0; i < count; i++) begin
            pick = $urandom_range(99);
            if (pick < 4) begin
                queue_word(CMD_ZERO_HEADING, 16'($urandom), 16'($urandom), 1'b0);
            end else if (pick < 7 && allow_restart) begin
                queue_word(CMD_RESTART, 16'($urandom), 16'($urandom), 1'b0);
                base = int'($urandom_range(4000)) - 2000;
                span = $urandom_range(60);
            end else if (pick < 15) begin
                cmd = 2'($urandom);
                if (cmd == CMD_RESTART && !allow_restart)
                    cmd = CMD_UNUSED;
                queue_word(cmd, 16'($urandom), 16'($urandom), $urandom_range(59) == 0);
            end else begin
                queue_word(CMD_SAMPLE, 16'(base + int'($urandom_range(2 * span)) - span),
                           16'($urandom), 1'b0);
            end
        end
    endfunction

    // one register write, one clock wide
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        case (idx)
            REG_SENSITIVITY:  tune.sens       = value[15:0];
            REG_ALPHA_MEAN:   tune.alpha_mean = value[16:0];
            REG_ALPHA_VAR:    tune.alpha_var  = value[16:0];
            REG_ALPHA_BIAS:   tune.alpha_bias = value[16:0];
            REG_VAR_THRESH:   tune.thresh     = value[47:0];
            REG_INITIAL_BIAS: tune.init_bias  = value[31:0];
            default: ;
        endcase
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic program_config(input logic [15:0] sens, input logic [16:0] a_mean,
                                  input logic [16:0] a_var, input logic [16:0] a_bias,
                                  input logic [47:0] thresh, input logic signed [31:0] init_bias);
        write_reg(REG_SENSITIVITY, 48'(sens));
        write_reg(REG_ALPHA_MEAN, 48'(a_mean));
        write_reg(REG_ALPHA_VAR, 48'(a_var));
        write_reg(REG_ALPHA_BIAS, 48'(a_bias));
        write_reg(REG_VAR_THRESH, 48'(thresh));
        write_reg(REG_INITIAL_BIAS, 48'(init_bias));
        settings_applied++;
    endtask

    // knobs and queue are touched on the falling edge, away from the clocked blocks
    task automatic set_pace(input int send_pct, input int recv_pct);
        @(negedge aclk);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
    endtask

    // every queued word answered, then a settling pause
    task automatic wait_for_results();
        while (results_seen != items_total)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // ------------------------------------------------------------------
    // sender: drives the input channel from pending_words
    // ------------------------------------------------------------------
    always @(posedge aclk) begin : drive_words
        sensor_word_t nxt;
        logic         launch;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            // word taken at this edge: predict its result now, with the current registers
            if (s_valid && s_ready) begin
                expected_words.push_back(advance_estimator(s_cmd, s_raw_sample, s_dt_q16));
                words_sent <= words_sent + 1;
            end
            // payload may only change once the current word is gone
            if (!s_valid || s_ready) begin
                launch = (pending_words.size() != 0) && ($urandom_range(99) >= send_idle_pct);
                // a held word goes out only with nothing in flight
                if (launch && pending_words[0].hold && (s_valid || words_sent != results_seen))
                    launch = 1'b0;
                if (launch) begin
                    nxt = pending_words.pop_front();
                    s_valid      <= 1'b1;
                    s_cmd        <= nxt.cmd;
                    s_raw_sample <= nxt.raw;
                    s_dt_q16     <= nxt.dt;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // receiver: random stalls and field-by-field check
    // ------------------------------------------------------------------
    task automatic check_field(input string field, input logic [63:0] want,
                               input logic [63:0] got);
        if (got !== want) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
                $display("result %0d %s: expected %h, got %h", results_seen, field, want, got);
        end
    endtask

    always @(posedge aclk) begin : watch_results
        est_word_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                results_seen <= results_seen + 1;
                if (expected_words.size() == 0) begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("result %0d arrived with no word outstanding", results_seen);
                end else begin
                    want = expected_words.pop_front();
                    check_field("rate", want.rate, m_rate_q16);
                    check_field("corrected_rate", want.corr, m_corrected_rate_q16);
                    check_field("mean", want.mean, m_mean_q16);
                    check_field("variance", want.variance, m_variance_q16);
                    check_field("bias", want.bias, m_bias_q16);
                    check_field("heading", want.heading, m_heading_q16);
                    check_field("lock_count", want.lock, m_lock_count);
                    check_field("calibrated", want.calibrated, m_calibrated);
                end
            end
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // hang guard
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("no progress after %0d cycles, %0d of %0d results seen",
                     cycle_count, results_seen, items_total);
            $display("Test completed with failures");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------
    initial begin : stimulus
        int send_pcts[3];
        int recv_pcts[3];
        send_pcts = '{60, 0, 16};
        recv_pcts = '{0, 60, 16};

        // synchronous reset, held low at start, then released
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: reset registers, raw and dt extremes, every command
        set_pace(30, 30);
        queue_word(CMD_SAMPLE, 16'sd0, 16'd0, 1'b0);
        queue_word(CMD_SAMPLE, 16'sh7FFF, 16'hFFFF, 1'b0);
        queue_word(CMD_SAMPLE, 16'sh8000, 16'hFFFF, 1'b0);
        queue_word(CMD_UNUSED, 16'sh5555, 16'hAAAA, 1'b0);
        queue_word(CMD_ZERO_HEADING, 16'shAAAA, 16'h5555, 1'b0);
        queue_word(CMD_RESTART, 16'sh0000, 16'h0000, 1'b0);
        wait_for_results();

        // weights above one, threshold zero so the bias never moves, most negative start bias
        program_config(16'hFFFF, 17'h1FFFF, 17'd65536, 17'h1FFFF, 48'd0, 32'sh8000_0000);
        set_pace(0, 0);
        queue_word(CMD_RESTART, 16'sd0, 16'd0, 1'b0);
        queue_word(CMD_SAMPLE, 16'sh8000, 16'hFFFF, 1'b0);
        queue_word(CMD_SAMPLE, 16'sh8000, 16'd1, 1'b0);
        queue_word(CMD_SAMPLE, 16'sh7FFF, 16'hFFFF, 1'b0);
        wait_for_results();

        // frozen mean far from the rate: widest deviation, square near full scale,
        // then the most positive start bias for the widest corrected rate
        program_config(16'hFFFF, 17'd0, 17'd65536, 17'd0, THRESH_ALL, 32'sh7FFF_FFFF);
        set_pace(0, 50);
        queue_word(CMD_SAMPLE, 16'sh8000, 16'hFFFF, 1'b0);
        queue_word(CMD_SAMPLE, 16'sh7FFF, 16'hFFFF, 1'b0);
        queue_word(CMD_RESTART, 16'sd0, 16'd0, 1'b0);
        queue_word(CMD_SAMPLE, 16'sh8000, 16'hFFFF, 1'b0);
        queue_word(CMD_ZERO_HEADING, 16'sd0, 16'd0, 1'b0);
        queue_word(CMD_UNUSED, 16'sd0, 16'd0, 1'b0);
        wait_for_results();

        // zero sensitivity so the rate stays zero; zero variance weight, full bias weight
        program_config(16'd0, 17'd1, 17'd0, 17'd65536, 48'd1, 32'sd0);
        set_pace(50, 0);
        queue_word(CMD_SAMPLE, 16'sh1234, 16'h4321, 1'b0);
        queue_word(CMD_SAMPLE, 16'sh8000, 16'hFFFF, 1'b0);
        wait_for_results();

        // long run with every sample under threshold: lock passes the calibration
        // level; no idling on either side
        program_config(16'd1147, 17'($urandom_range(131071)), 17'($urandom_range(70000)),
                       17'($urandom_range(131071)), THRESH_ALL, 32'(int'($urandom_range(20000)) - 10000));
        set_pace(0, 0);
        queue_noisy_run(300, 1'b0);
        wait_for_results();

        // calibration runs with random registers under each idling mix
        for (int p = 0; p < 3; p++) begin
            program_config(16'($urandom_range(4000, 200)), 17'($urandom_range(131071)),
                           17'($urandom_range(70000)), 17'($urandom_range(131071)),
                           48'($urandom_range(1 << 22)),
                           32'(int'($urandom_range(20000)) - 10000));
            set_pace(send_pcts[p], recv_pcts[p]);
            for (int r = 0; r < 3; r++)
                queue_noisy_run(40, 1'b1);
            wait_for_results();
        end

        // let anything stray show up before closing
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (expected_words.size() != 0) begin
            $display("%0d predicted results never arrived", expected_words.size());
            mismatches += expected_words.size();
        end

        $display("checked %0d result words from %0d input words over %0d register settings",
                 results_seen, items_total, settings_applied);
        $display("lock count peaked at %0d, calibration %s",
                 peak_lock, (peak_lock >= CAL_LEVEL) ? "reached" : "not reached");
        if (mismatches == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
